// ===== rtl/sbdt_pkg.sv =====
package sbdt_pkg;

    // Result list bound per query
    localparam int MAX_RESULTS = 6;
    localparam int NF_W        = $clog2(MAX_RESULTS + 1);
    localparam int FI_W        = $clog2(MAX_RESULTS);
    localparam int UPC_W       = 4;

    // Microprogram step addresses
    typedef enum logic [UPC_W-1:0] {
        UP_IDLE  = 4'd0,
        UP_RJ    = 4'd1,
        UP_RRD   = 4'd2,
        UP_RWAIT = 4'd3,
        UP_RWR   = 4'd4,
        UP_RDONE = 4'd5,
        UP_QINIT = 4'd6,
        UP_QRD   = 4'd7,
        UP_QEV   = 4'd8,
        UP_EMIT  = 4'd9,
        UP_RET   = 4'd10,
        UP_ZERO  = 4'd11
    } t_upc;

    // Jump conditions; taken goes to the target, else fall through
    typedef enum logic [2:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_DISPATCH,
        JC_X_MORE,
        JC_J_MORE,
        JC_ZERO_Q,
        JC_EVAL_MORE,
        JC_EMIT_MORE
    } t_jc;

    // One control word
    typedef struct packed {
        logic sb_rd;     // read S-box entry at x, advance x
        logic row_wr;    // write transformed row at j, advance j
        logic eval;      // test row j against the query, advance j
        logic set_cur;   // mark ANF rows current
        logic q_init;    // start a query walk
        logic j_init;    // start a rebuild
        logic emit;      // put out one word of the found list
        logic emit_zero; // put out the zero-mask answer
        t_jc  jc;
        t_upc tgt;
    } t_ctl;

    // Control store
    function automatic t_ctl ucode(input t_upc u);
        t_ctl c;
        c = '{sb_rd: 1'b0, row_wr: 1'b0, eval: 1'b0, set_cur: 1'b0, q_init: 1'b0,
              j_init: 1'b0, emit: 1'b0, emit_zero: 1'b0, jc: JC_NEXT, tgt: UP_IDLE};
        unique case (u)
            UP_IDLE: begin
                c.jc = JC_DISPATCH;
            end
            UP_RJ: begin
                c.j_init = 1'b1;
            end
            UP_RRD: begin
                c.sb_rd = 1'b1;
                c.jc    = JC_X_MORE;
                c.tgt   = UP_RRD;
            end
            UP_RWAIT: begin
                c.jc = JC_NEXT;
            end
            UP_RWR: begin
                c.row_wr = 1'b1;
                c.jc     = JC_J_MORE;
                c.tgt    = UP_RRD;
            end
            UP_RDONE: begin
                c.set_cur = 1'b1;
            end
            UP_QINIT: begin
                c.q_init = 1'b1;
                c.jc     = JC_ZERO_Q;
                c.tgt    = UP_ZERO;
            end
            UP_QRD: begin
                c.jc = JC_NEXT;
            end
            UP_QEV: begin
                c.eval = 1'b1;
                c.jc   = JC_EVAL_MORE;
                c.tgt  = UP_QRD;
            end
            UP_EMIT: begin
                c.emit = 1'b1;
                c.jc   = JC_EMIT_MORE;
                c.tgt  = UP_EMIT;
            end
            UP_RET: begin
                c.jc  = JC_ALWAYS;
                c.tgt = UP_IDLE;
            end
            UP_ZERO: begin
                c.emit_zero = 1'b1;
                c.jc        = JC_ALWAYS;
                c.tgt       = UP_IDLE;
            end
            default: begin
                c.jc  = JC_ALWAYS;
                c.tgt = UP_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/sbox_division_trail_engine.sv =====
// S-box division trail engine. A load word (operation 0) writes one S-box
// entry and gives no result. A query word (operation 1) gives one to six
// result words in ascending out_mask order, each shown for one cycle with
// o_valid; the receiver cannot stall, and o_last marks the final word. A
// query runs a row walk that reads the ANF rows from memory one at a time
// and tests each against the query mask; the walk ends early once the sixth
// word is found, and a zero mask gives its single word without a walk. The
// first query after any load first rebuilds the ANF rows, with one S-box
// memory read per truth-table bit of each row. busy is high for the whole
// run; every S-box entry must be loaded before a query.
module sbox_division_trail_engine import sbdt_pkg::*; #(
    parameter int SBOX_BITS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_operation,
    input  logic [SBOX_BITS-1:0] i_entry_index,
    input  logic [SBOX_BITS-1:0] i_entry_value,
    input  logic [SBOX_BITS-1:0] i_query_mask,
    output logic                 o_valid,
    output logic [SBOX_BITS-1:0] o_in_mask,
    output logic [SBOX_BITS-1:0] o_out_mask,
    output logic                 o_found,
    output logic                 o_last
);

    localparam int N = 1 << SBOX_BITS;

    // Moebius transform of a truth table, one butterfly stage per input bit
    function automatic logic [N-1:0] mobius(input logic [N-1:0] tv);
        logic [N-1:0] a;
        a = tv;
        for (int k = 0; k < SBOX_BITS; k++) begin
            for (int x = 0; x < N; x++) begin
                if (((x >> k) & 1) == 1) begin
                    a[x] = a[x] ^ a[x ^ (1 << k)];
                end
            end
        end
        return a;
    endfunction

    t_upc                 r_upc, n_upc;
    t_ctl                 ctl;
    logic                 r_cur;
    logic [SBOX_BITS-1:0] r_x, r_xd, r_j, r_qmask;
    logic                 r_cap;
    logic [N-1:0]         r_t;
    logic [NF_W-1:0]      r_nf, r_e;
    logic [SBOX_BITS-1:0] r_found [MAX_RESULTS];

    logic                 acc;
    logic                 sb_we;
    logic [SBOX_BITS-1:0] sb_addr, sb_rdata;
    logic [N-1:0]         row_rdata;
    logic                 cov, minimal, hit, emit_last, take;

    assign ctl   = ucode(r_upc);
    assign busy  = (r_upc != UP_IDLE);
    assign acc   = start && !busy;
    assign sb_we = acc && !i_operation;

    // S-box table: written on load, swept by address x during rebuild
    assign sb_addr = ctl.sb_rd ? r_x : i_entry_index;

    sbdt_ram #(
        .WIDTH (SBOX_BITS),
        .DEPTH (N)
    ) u_sbox_ram (
        .i_clk   (i_clk),
        .i_we    (sb_we),
        .i_addr  (sb_addr),
        .i_wdata (i_entry_value),
        .o_rdata (sb_rdata)
    );

    // ANF rows, one per output mask j
    sbdt_ram #(
        .WIDTH (N),
        .DEPTH (N)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ctl.row_wr),
        .i_addr  (r_j),
        .i_wdata (mobius(r_t)),
        .o_rdata (row_rdata)
    );

    // Row test: some monomial covers the query, and no found mask is a subset
    always_comb begin
        cov     = 1'b0;
        minimal = 1'b1;
        for (int m = 0; m < N; m++) begin
            if (row_rdata[m] && ((SBOX_BITS'(m) & r_qmask) == r_qmask)) begin
                cov = 1'b1;
            end
        end
        for (int s = 0; s < MAX_RESULTS; s++) begin
            if ((NF_W'(s) < r_nf) && ((r_found[s] & r_j) == r_found[s])) begin
                minimal = 1'b0;
            end
        end
        hit = cov && minimal;
    end

    assign emit_last = (r_nf == '0) || (r_e == r_nf - NF_W'(1));

    // Sequencer next step
    always_comb begin
        unique case (ctl.jc)
            JC_NEXT:      take = 1'b0;
            JC_ALWAYS:    take = 1'b1;
            JC_DISPATCH:  take = 1'b0;
            JC_X_MORE:    take = (r_x != SBOX_BITS'(N - 1));
            JC_J_MORE:    take = (r_j != SBOX_BITS'(N - 1));
            JC_ZERO_Q:    take = (r_qmask == '0);
            JC_EVAL_MORE: take = (r_j != SBOX_BITS'(N - 1)) &&
                                 !(hit && (r_nf == NF_W'(MAX_RESULTS - 1)));
            JC_EMIT_MORE: take = !emit_last;
            default:      take = 1'b1;
        endcase
        if (ctl.jc == JC_DISPATCH) begin
            if (acc && i_operation) begin
                n_upc = r_cur ? UP_QINIT : UP_RJ;
            end else begin
                n_upc = UP_IDLE;
            end
        end else if (take) begin
            n_upc = ctl.tgt;
        end else begin
            n_upc = t_upc'(r_upc + UPC_W'(1));
        end
    end

    // Datapath and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc   <= UP_IDLE;
            r_cur   <= 1'b0;
            r_cap   <= 1'b0;
            r_nf    <= '0;
            o_valid <= 1'b0;
        end else begin
            r_upc   <= n_upc;
            r_cap   <= ctl.sb_rd;
            r_xd    <= r_x;
            o_valid <= 1'b0;

            if (sb_we) begin
                r_cur <= 1'b0;
            end
            if (acc && i_operation) begin
                r_qmask <= i_query_mask;
            end
            if (ctl.set_cur) begin
                r_cur <= 1'b1;
            end

            // rebuild: truth table of the product of the bits in j
            if (ctl.j_init) begin
                r_j <= SBOX_BITS'(1);
                r_x <= '0;
            end
            if (ctl.sb_rd) begin
                r_x <= r_x + SBOX_BITS'(1);
            end
            if (r_cap) begin
                r_t[r_xd] <= ((sb_rdata & r_j) == r_j);
            end
            if (ctl.row_wr) begin
                r_j <= r_j + SBOX_BITS'(1);
                r_x <= '0;
            end

            // query walk
            if (ctl.q_init) begin
                r_j  <= SBOX_BITS'(1);
                r_nf <= '0;
                r_e  <= '0;
            end
            if (ctl.eval) begin
                r_j <= r_j + SBOX_BITS'(1);
                if (hit) begin
                    r_found[r_nf[FI_W-1:0]] <= r_j;
                    r_nf                    <= r_nf + NF_W'(1);
                end
            end

            // result words
            if (ctl.emit) begin
                o_valid    <= 1'b1;
                o_in_mask  <= r_qmask;
                o_out_mask <= (r_nf == '0) ? '0 : r_found[r_e[FI_W-1:0]];
                o_found    <= (r_nf != '0);
                o_last     <= emit_last;
                r_e        <= r_e + NF_W'(1);
            end
            if (ctl.emit_zero) begin
                o_valid    <= 1'b1;
                o_in_mask  <= '0;
                o_out_mask <= '0;
                o_found    <= 1'b1;
                o_last     <= 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_upc == UP_EMIT || r_upc == UP_ZERO))
        else $error("result word without an emit step");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result word after the final word of a query");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_operation) |=> busy)
        else $error("query accepted but engine not busy");

    a_load_stale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sb_we |=> !r_cur)
        else $error("ANF rows still marked current after a load");

    a_nf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.emit |-> (r_nf <= NF_W'(MAX_RESULTS)))
        else $error("found list overran its bound");
`endif

endmodule

// ===== rtl/sbdt_ram.sv =====
module sbdt_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
